// ===== rtl/core/pwb_pkg.sv =====
// pwb_pkg: shared types and constants of the perspective warp block
// payload structs, coefficient register map and fixed arithmetic widths
// no dependencies
package pwb_pkg;

  // coefficient registers
  localparam int CoefW   = 48;
  localparam int NumCoef = 8;
  localparam int DataW   = 64;
  localparam int AddrW   = 6;

  // pixel and coordinate fields
  localparam int CoordW = 12;
  localparam int ChanW  = 8;
  localparam int PixW   = 3 * ChanW;

  // homography arithmetic: 48b coef times 13b signed coordinate, sum of three
  localparam int ProdW = 61;
  localparam int SumW  = 62;
  localparam int MagW  = 61;

  // defaults handed to the top level
  localparam int DefImgWidth   = 512;
  localparam int DefImgHeight  = 512;
  localparam int DefQueueDepth = 4;

  // 1.0 with 32 fraction bits
  localparam logic [CoefW-1:0]       CoefOne = 48'h0001_0000_0000;
  localparam logic signed [SumW-1:0] SumOne  = 62'sh1_0000_0000;

  typedef enum logic [2:0] {
    REG_H00,
    REG_H01,
    REG_H02,
    REG_H10,
    REG_H11,
    REG_H12,
    REG_H20,
    REG_H21
  } pwb_reg_e;

  typedef logic [NumCoef-1:0][CoefW-1:0] pwb_coef_t;

  typedef struct packed {
    logic              mode;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [ChanW-1:0]  in_red;
    logic [ChanW-1:0]  in_green;
    logic [ChanW-1:0]  in_blue;
  } pwb_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             inside_res;
  } pwb_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              warp;
    logic              pre_in;
    logic [MagW-1:0]   px;
    logic [MagW-1:0]   py;
    logic [MagW-1:0]   pd;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [PixW-1:0]   rgb;
  } pwb_cls_t;

endpackage

// ===== rtl/core/pwb_ram.sv =====
// pwb_ram: generic one-write two-read memory with registered read data
// no dependencies
module pwb_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== rtl/core/pwb_regs.sv =====
// pwb_regs: apb register file for the eight homography coefficients
// depends on pwb_pkg
module pwb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pwb_pkg::AddrW-1:0]  paddr,
  input  logic [pwb_pkg::DataW-1:0]  pwdata,
  output logic [pwb_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output pwb_pkg::pwb_coef_t         coef_o
);

  // identity mapping after reset: h_00 and h_11 at 1.0, the rest zero
  localparam pwb_pkg::pwb_coef_t CoefReset = {
    {(3 * pwb_pkg::CoefW){1'b0}}, pwb_pkg::CoefOne,
    {(3 * pwb_pkg::CoefW){1'b0}}, pwb_pkg::CoefOne
  };

  pwb_pkg::pwb_coef_t coef_q;
  pwb_pkg::pwb_reg_e  idx;
  logic               wr_en;

  // registers sit on 8 byte boundaries
  assign idx   = pwb_pkg::pwb_reg_e'(paddr[pwb_pkg::AddrW-1:3]);
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefReset;
    end else if (wr_en) begin
      coef_q[idx] <= pwdata[pwb_pkg::CoefW-1:0];
    end
  end

  // read back sign extended
  assign prdata = {{(pwb_pkg::DataW - pwb_pkg::CoefW){coef_q[idx][pwb_pkg::CoefW-1]}},
                   coef_q[idx]};
  assign pready = 1'b1;
  assign coef_o = coef_q;

endmodule

// ===== rtl/core/pwb_front.sv =====
// pwb_front: accepts items, evaluates the homography and classifies each item
// four register stages; depends on pwb_pkg
module pwb_front #(
  parameter int ImgWidth  = pwb_pkg::DefImgWidth,
  parameter int ImgHeight = pwb_pkg::DefImgHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwb_pkg::pwb_coef_t coef_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pwb_pkg::pwb_in_t   in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pwb_pkg::pwb_cls_t  out_item_o
);

  localparam int LgW = $clog2(ImgWidth);
  localparam int LgH = $clog2(ImgHeight);
  localparam int Lg  = (LgW > LgH) ? LgW : LgH;

  typedef struct packed {
    logic                       v;
    logic                       warp;
    logic [pwb_pkg::CoordW-1:0] col;
    logic [pwb_pkg::CoordW-1:0] row;
    logic [pwb_pkg::PixW-1:0]   rgb;
  } meta_t;

  meta_t                               m1_q, m2_q, m3_q;
  logic signed [pwb_pkg::ProdW-1:0]    pr_q [6];
  logic signed [pwb_pkg::SumW-1:0]     cst  [3];
  logic signed [pwb_pkg::SumW-1:0]     sm_q [3];
  logic signed [pwb_pkg::SumW-1:0]     ng   [3];
  logic [pwb_pkg::MagW-1:0]            mg_q [3];
  logic                                zero_q, bad_q;
  logic                                neg_p;
  logic                                load_ok;
  logic                                ov_u, ov_v;
  logic                                v4_q;
  pwb_pkg::pwb_cls_t                   c4_q;
  logic                                en;

  // the whole front holds while the last stage cannot hand over
  assign en         = !(v4_q && out_stall_i);
  assign in_stall_o = !en;

  // loads outside the image are dropped here
  assign load_ok = (int'(in_item_i.col) < ImgWidth) && (int'(in_item_i.row) < ImgHeight);

  // stage 1: item control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
    end else if (en) begin
      m1_q.v    <= in_valid_i && (in_item_i.mode || load_ok);
      m1_q.warp <= in_item_i.mode;
      m1_q.col  <= in_item_i.col;
      m1_q.row  <= in_item_i.row;
      m1_q.rgb  <= {in_item_i.in_red, in_item_i.in_green, in_item_i.in_blue};
    end
  end

  // stage 1: six coefficient products, x terms even, y terms odd
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[2*k]   <= pwb_pkg::ProdW'($signed(coef_i[3*k])) *
                       pwb_pkg::ProdW'($signed({1'b0, in_item_i.col}));
        pr_q[2*k+1] <= pwb_pkg::ProdW'($signed(coef_i[3*k+1])) *
                       pwb_pkg::ProdW'($signed({1'b0, in_item_i.row}));
      end
    end
  end

  // stage 2: constant terms, the denominator one is fixed at 1.0
  assign cst[0] = pwb_pkg::SumW'($signed(coef_i[pwb_pkg::REG_H02]));
  assign cst[1] = pwb_pkg::SumW'($signed(coef_i[pwb_pkg::REG_H12]));
  assign cst[2] = pwb_pkg::SumOne;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_q <= '0;
    end else if (en) begin
      m2_q <= m1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sm_q[k] <= pwb_pkg::SumW'(pr_q[2*k]) + pwb_pkg::SumW'(pr_q[2*k+1]) + cst[k];
      end
    end
  end

  // stage 3: make the denominator positive
  assign neg_p = sm_q[2][pwb_pkg::SumW-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ng[k] = neg_p ? -sm_q[k] : sm_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_q <= '0;
    end else if (en) begin
      m3_q <= m2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mg_q[k] <= ng[k][pwb_pkg::MagW-1:0];
      end
      zero_q <= (sm_q[2] == '0);
      bad_q  <= ng[0][pwb_pkg::SumW-1] || ng[1][pwb_pkg::SumW-1];
    end
  end

  // stage 4: quotient would reach 2^Lg in its integer part
  assign ov_u = (mg_q[0] >> Lg) >= mg_q[2];
  assign ov_v = (mg_q[1] >> Lg) >= mg_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= m3_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q.warp   <= m3_q.warp;
      c4_q.pre_in <= !zero_q && !bad_q && !ov_u && !ov_v;
      c4_q.px     <= mg_q[0];
      c4_q.py     <= mg_q[1];
      c4_q.pd     <= mg_q[2];
      c4_q.col    <= m3_q.col;
      c4_q.row    <= m3_q.row;
      c4_q.rgb    <= m3_q.rgb;
    end
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = c4_q;

endmodule

// ===== rtl/core/pwb_fifo.sv =====
// pwb_fifo: short queue of classified items between front and back
// depends on pwb_pkg
module pwb_fifo #(
  parameter int Depth = pwb_pkg::DefQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_stall_o,
  input  pwb_pkg::pwb_cls_t push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_stall_i,
  output pwb_pkg::pwb_cls_t pop_item_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  pwb_pkg::pwb_cls_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_stall_o = (cnt_q == CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow a lone push");
`endif

endmodule

// ===== rtl/core/pwb_back.sv =====
// pwb_back: divides to source coordinates, reads four neighbours and blends
// uses pwb_ram for the source image; depends on pwb_pkg
module pwb_back #(
  parameter int ImgWidth  = pwb_pkg::DefImgWidth,
  parameter int ImgHeight = pwb_pkg::DefImgHeight
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pwb_pkg::pwb_cls_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pwb_pkg::pwb_out_t out_item_o
);

  localparam int LgW   = $clog2(ImgWidth);
  localparam int LgH   = $clog2(ImgHeight);
  localparam int Lg    = (LgW > LgH) ? LgW : LgH;
  localparam int QB    = Lg + 8;
  localparam int RemW  = pwb_pkg::MagW + 1;
  localparam int XW    = LgW;
  localparam int YW    = LgH;
  localparam int Depth = ImgWidth * ImgHeight;
  localparam int AW    = $clog2(Depth);
  localparam int WW    = 17;
  localparam int AccW  = 24;
  localparam logic [QB:0]   ULim  = (QB + 1)'(ImgWidth * 256);
  localparam logic [QB:0]   VLim  = (QB + 1)'(ImgHeight * 256);
  localparam logic [XW-1:0] XLast = XW'(ImgWidth - 1);
  localparam logic [YW-1:0] YLast = YW'(ImgHeight - 1);

  typedef struct packed {
    logic                       v;
    logic                       warp;
    logic                       pre_in;
    logic [RemW-1:0]            ru;
    logic [RemW-1:0]            rv;
    logic [QB-1:0]              lu;
    logic [QB-1:0]              lv;
    logic [QB-1:0]              qu;
    logic [QB-1:0]              qv;
    logic [pwb_pkg::MagW-1:0]   d;
    logic [pwb_pkg::CoordW-1:0] col;
    logic [pwb_pkg::CoordW-1:0] row;
    logic [pwb_pkg::PixW-1:0]   rgb;
  } dv_t;

  typedef struct packed {
    logic                     v;
    logic                     warp;
    logic                     in_img;
    logic [XW-1:0]            x0;
    logic [XW-1:0]            x1;
    logic [AW-1:0]            rb0;
    logic [AW-1:0]            rb1;
    logic [7:0]               fx;
    logic [7:0]               fy;
    logic [pwb_pkg::PixW-1:0] rgb;
  } st_a_t;

  typedef struct packed {
    logic          v;
    logic          warp;
    logic          in_img;
    logic [WW-1:0] w00;
    logic [WW-1:0] w10;
    logic [WW-1:0] w01;
    logic [WW-1:0] w11;
  } st_b_t;

  dv_t                      dv_q  [QB+1];
  dv_t                      dv_nx [QB];
  dv_t                      dv_in;
  st_a_t                    a_d, a_q;
  st_b_t                    b_d, b_q;
  logic [YW-1:0]            y0, y1;
  logic [AW-1:0]            ad00, ad10, ad01, ad11;
  logic [8:0]               fxc, fyc;
  logic [pwb_pkg::PixW-1:0] s00, s10, s01, s11;
  logic [AccW-1:0]          acc [3];
  logic                     ram_we;
  logic                     en;
  logic                     out_valid_q;
  pwb_pkg::pwb_out_t        out_q, out_d;

  // back pipeline moves as one unless the result register is blocked
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // divider entry: high part of the numerator as remainder, rest shifted in
  always_comb begin
    dv_in        = '0;
    dv_in.v      = in_valid_i;
    dv_in.warp   = in_item_i.warp;
    dv_in.pre_in = in_item_i.pre_in;
    dv_in.ru     = RemW'(in_item_i.px >> Lg);
    dv_in.rv     = RemW'(in_item_i.py >> Lg);
    dv_in.lu     = {in_item_i.px[Lg-1:0], 8'h00};
    dv_in.lv     = {in_item_i.py[Lg-1:0], 8'h00};
    dv_in.d      = in_item_i.pd;
    dv_in.col    = in_item_i.col;
    dv_in.row    = in_item_i.row;
    dv_in.rgb    = in_item_i.rgb;
  end

  // restoring division, one quotient bit of u and of v per stage
  always_comb begin
    logic [RemW-1:0] tu, tv, dd;
    for (int k = 0; k < QB; k++) begin
      dv_nx[k]    = dv_q[k];
      dd          = {1'b0, dv_q[k].d};
      tu          = {dv_q[k].ru[RemW-2:0], dv_q[k].lu[QB-1]};
      tv          = {dv_q[k].rv[RemW-2:0], dv_q[k].lv[QB-1]};
      dv_nx[k].lu = dv_q[k].lu << 1;
      dv_nx[k].lv = dv_q[k].lv << 1;
      if (tu >= dd) begin
        dv_nx[k].ru = tu - dd;
        dv_nx[k].qu = {dv_q[k].qu[QB-2:0], 1'b1};
      end else begin
        dv_nx[k].ru = tu;
        dv_nx[k].qu = {dv_q[k].qu[QB-2:0], 1'b0};
      end
      if (tv >= dd) begin
        dv_nx[k].rv = tv - dd;
        dv_nx[k].qv = {dv_q[k].qv[QB-2:0], 1'b1};
      end else begin
        dv_nx[k].rv = tv;
        dv_nx[k].qv = {dv_q[k].qv[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB; k++) begin
        dv_q[k] <= '0;
      end
    end else if (en) begin
      dv_q[0] <= dv_in;
      for (int k = 0; k < QB; k++) begin
        dv_q[k+1] <= dv_nx[k];
      end
    end
  end

  // stage a: range check, neighbour coordinates with edge clamp, row bases
  always_comb begin
    a_d        = '0;
    a_d.v      = dv_q[QB].v;
    a_d.warp   = dv_q[QB].warp;
    a_d.in_img = dv_q[QB].warp && dv_q[QB].pre_in &&
                 ({1'b0, dv_q[QB].qu} < ULim) && ({1'b0, dv_q[QB].qv} < VLim);
    if (!dv_q[QB].warp) begin
      a_d.x0 = dv_q[QB].col[XW-1:0];
      y0     = dv_q[QB].row[YW-1:0];
    end else if (a_d.in_img) begin
      a_d.x0 = dv_q[QB].qu[XW+7:8];
      y0     = dv_q[QB].qv[YW+7:8];
    end else begin
      a_d.x0 = '0;
      y0     = '0;
    end
    a_d.x1  = (a_d.x0 == XLast) ? a_d.x0 : a_d.x0 + 1'b1;
    y1      = (y0 == YLast) ? y0 : y0 + 1'b1;
    a_d.rb0 = AW'(y0) * AW'(ImgWidth);
    a_d.rb1 = AW'(y1) * AW'(ImgWidth);
    a_d.fx  = dv_q[QB].qu[7:0];
    a_d.fy  = dv_q[QB].qv[7:0];
    a_d.rgb = dv_q[QB].rgb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en) begin
      a_q <= a_d;
    end
  end

  // neighbour addresses; a load writes at its own position
  assign ad00   = a_q.rb0 + AW'(a_q.x0);
  assign ad10   = a_q.rb0 + AW'(a_q.x1);
  assign ad01   = a_q.rb1 + AW'(a_q.x0);
  assign ad11   = a_q.rb1 + AW'(a_q.x1);
  assign ram_we = a_q.v && !a_q.warp && en;

  // top row of neighbours
  pwb_ram #(
    .Width(pwb_pkg::PixW),
    .Depth(Depth)
  ) u_ram_top (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ad00),
    .wdata_i  (a_q.rgb),
    .re_i     (en),
    .raddr_a_i(ad00),
    .raddr_b_i(ad10),
    .rdata_a_o(s00),
    .rdata_b_o(s10)
  );

  // bottom row of neighbours, same contents
  pwb_ram #(
    .Width(pwb_pkg::PixW),
    .Depth(Depth)
  ) u_ram_bot (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ad00),
    .wdata_i  (a_q.rgb),
    .re_i     (en),
    .raddr_a_i(ad01),
    .raddr_b_i(ad11),
    .rdata_a_o(s01),
    .rdata_b_o(s11)
  );

  // stage b: bilinear weights alongside the memory read
  assign fxc = 9'd256 - {1'b0, a_q.fx};
  assign fyc = 9'd256 - {1'b0, a_q.fy};

  always_comb begin
    b_d        = '0;
    b_d.v      = a_q.v;
    b_d.warp   = a_q.warp;
    b_d.in_img = a_q.in_img;
    b_d.w00    = WW'(fxc) * WW'(fyc);
    b_d.w10    = WW'(a_q.fx) * WW'(fyc);
    b_d.w01    = WW'(fxc) * WW'(a_q.fy);
    b_d.w11    = WW'(a_q.fx) * WW'(a_q.fy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (en) begin
      b_q <= b_d;
    end
  end

  // blend per channel, round half up
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = AccW'(s00[pwb_pkg::PixW-1-8*c -: 8]) * AccW'(b_q.w00) +
               AccW'(s10[pwb_pkg::PixW-1-8*c -: 8]) * AccW'(b_q.w10) +
               AccW'(s01[pwb_pkg::PixW-1-8*c -: 8]) * AccW'(b_q.w01) +
               AccW'(s11[pwb_pkg::PixW-1-8*c -: 8]) * AccW'(b_q.w11) +
               AccW'(32768);
    end
  end

  always_comb begin
    out_d            = '0;
    out_d.inside_res = b_q.in_img;
    if (b_q.in_img) begin
      out_d.out_red   = acc[0][AccW-1:16];
      out_d.out_green = acc[1][AccW-1:16];
      out_d.out_blue  = acc[2][AccW-1:16];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= b_q.v && b_q.warp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.inside_res) |->
    (out_q.out_red == '0 && out_q.out_green == '0 && out_q.out_blue == '0))
    else $error("outside result carries nonzero color");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && b_q.v && !b_q.warp) |=> !out_valid_q)
    else $error("load item produced a result");
`endif

endmodule

// ===== rtl/core/perspective_warp_bilinear.sv =====
// perspective_warp_bilinear: top level of the homography warp with bilinear blend
// instantiates pwb_regs, pwb_front, pwb_fifo and pwb_back; depends on pwb_pkg

// One item per clock is taken and one result per warp item leaves per clock
// when neither side stalls. A load item (mode 0) writes one source pixel into
// the on-chip image and gives no result; loads past the image edge are
// dropped. A warp item (mode 1) gives one result after it has passed four
// front stages for the homography, the queue, the divider stages that form
// one quotient bit of u and v each, then the address, memory read and result
// stages. The image is held twice, ImgWidth * ImgHeight words of 24 bits each,
// so the four neighbours are read in the same cycle. The image has no reset
// and no clearing pass: every pixel a warp may touch must be loaded first.
// The user must write coefficients over APB only while the block is idle;
// the block itself does not enforce this.
module perspective_warp_bilinear #(
  parameter int ImgWidth   = pwb_pkg::DefImgWidth,
  parameter int ImgHeight  = pwb_pkg::DefImgHeight,
  parameter int QueueDepth = pwb_pkg::DefQueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pwb_pkg::AddrW-1:0] paddr,
  input  logic [pwb_pkg::DataW-1:0] pwdata,
  output logic [pwb_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  pwb_pkg::pwb_in_t          in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pwb_pkg::pwb_out_t         out_item_o
);

  pwb_pkg::pwb_coef_t coef;
  pwb_pkg::pwb_cls_t  fr_item, bk_item;
  logic               fr_valid, fr_stall;
  logic               bk_valid, bk_stall;

  // coefficient registers
  pwb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coef_o (coef)
  );

  // homography and classification
  pwb_front #(
    .ImgWidth (ImgWidth),
    .ImgHeight(ImgHeight)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(fr_valid),
    .out_stall_i(fr_stall),
    .out_item_o (fr_item)
  );

  // decoupling queue
  pwb_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_stall_o(fr_stall),
    .push_item_i (fr_item),
    .pop_valid_o (bk_valid),
    .pop_stall_i (bk_stall),
    .pop_item_o  (bk_item)
  );

  // division, image store and blend
  pwb_back #(
    .ImgWidth (ImgWidth),
    .ImgHeight(ImgHeight)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bk_valid),
    .in_stall_o (bk_stall),
    .in_item_i  (bk_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== tb/tb_perspective_warp_bilinear.sv =====
// tb_perspective_warp_bilinear: self-checking testbench of the homography warp block
// loads a source patch, sweeps coefficient sets over apb and checks each warped pixel
// depends on pwb_pkg and perspective_warp_bilinear
`timescale 1ns / 100ps

// predicts warped pixels and compares them with what the block returns
class warp_scoreboard;
  localparam int ImgW = pwb_pkg::DefImgWidth;
  localparam int ImgH = pwb_pkg::DefImgHeight;

  logic signed [pwb_pkg::CoefW-1:0] coef [pwb_pkg::NumCoef];
  bit [pwb_pkg::PixW-1:0]           image [int];
  pwb_pkg::pwb_out_t                pixels_due [$];
  int                               errors;

  function new();
    foreach (coef[i]) coef[i] = '0;
    coef[pwb_pkg::REG_H00] = pwb_pkg::CoefOne;
    coef[pwb_pkg::REG_H11] = pwb_pkg::CoefOne;
    errors = 0;
  endfunction

  function void set_coef(pwb_pkg::pwb_reg_e idx, logic [pwb_pkg::CoefW-1:0] val);
    coef[idx] = val;
  endfunction

  // returns 0 when the mapped position needs a pixel never loaded
  function bit warp_pixel(int col, int row, output pwb_pkg::pwb_out_t res);
    logic signed [63:0] x, y, px, py, pd;
    logic [71:0] u, v;
    int x0, x1, y0, y1, fx, fy, acc, sh;
    int key [4];
    int w [4];
    res = '0;
    x  = col;
    y  = row;
    px = coef[pwb_pkg::REG_H00] * x + coef[pwb_pkg::REG_H01] * y + coef[pwb_pkg::REG_H02];
    py = coef[pwb_pkg::REG_H10] * x + coef[pwb_pkg::REG_H11] * y + coef[pwb_pkg::REG_H12];
    pd = coef[pwb_pkg::REG_H20] * x + coef[pwb_pkg::REG_H21] * y + (64'sd1 <<< 32);
    // zero denominator counts as outside
    if (pd == 0) return 1;
    if (pd < 0) begin
      pd = -pd;
      px = -px;
      py = -py;
    end
    if (px < 0 || py < 0) return 1;
    u = ({8'd0, px} << 8) / {8'd0, pd};
    v = ({8'd0, py} << 8) / {8'd0, pd};
    if ((u >> 8) >= ImgW || (v >> 8) >= ImgH) return 1;
    x0 = int'(u >> 8);
    fx = int'(u[7:0]);
    y0 = int'(v >> 8);
    fy = int'(v[7:0]);
    // neighbours past the edge clamp to it
    x1 = (x0 + 1 < ImgW) ? x0 + 1 : ImgW - 1;
    y1 = (y0 + 1 < ImgH) ? y0 + 1 : ImgH - 1;
    key[0] = y0 * ImgW + x0;
    key[1] = y0 * ImgW + x1;
    key[2] = y1 * ImgW + x0;
    key[3] = y1 * ImgW + x1;
    foreach (key[k]) if (!image.exists(key[k])) return 0;
    w[0] = (256 - fx) * (256 - fy);
    w[1] = fx * (256 - fy);
    w[2] = (256 - fx) * fy;
    w[3] = fx * fy;
    for (int ch = 0; ch < 3; ch++) begin
      sh  = 16 - 8 * ch;
      acc = 32768;
      foreach (key[k]) acc += int'((image[key[k]] >> sh) & 8'hff) * w[k];
      acc = (acc >> 16) & 255;
      if (ch == 0) res.out_red = acc[7:0];
      else if (ch == 1) res.out_green = acc[7:0];
      else res.out_blue = acc[7:0];
    end
    res.inside_res = 1'b1;
    return 1;
  endfunction

  // note an accepted input item
  function void note_item(pwb_pkg::pwb_in_t it);
    pwb_pkg::pwb_out_t res;
    if (it.mode == 1'b0) begin
      if (it.col < ImgW && it.row < ImgH)
        image[it.row * ImgW + it.col] = {it.in_red, it.in_green, it.in_blue};
    end else begin
      void'(warp_pixel(it.col, it.row, res));
      pixels_due = {pixels_due, res};
    end
  endfunction

  // compare an accepted result with the oldest prediction
  function void check_pixel(pwb_pkg::pwb_out_t got);
    pwb_pkg::pwb_out_t exp_px;
    if (pixels_due.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      errors++;
      return;
    end
    exp_px = pixels_due.pop_front();
    if (got.out_red !== exp_px.out_red) begin
      $display("%0t: out_red exp %h got %h", $realtime, exp_px.out_red, got.out_red);
      errors++;
    end
    if (got.out_green !== exp_px.out_green) begin
      $display("%0t: out_green exp %h got %h", $realtime, exp_px.out_green, got.out_green);
      errors++;
    end
    if (got.out_blue !== exp_px.out_blue) begin
      $display("%0t: out_blue exp %h got %h", $realtime, exp_px.out_blue, got.out_blue);
      errors++;
    end
    if (got.inside_res !== exp_px.inside_res) begin
      $display("%0t: inside_res exp %b got %b", $realtime, exp_px.inside_res,
               got.inside_res);
      errors++;
    end
  endfunction
endclass

module tb_perspective_warp_bilinear;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeWarp = 1'b1;
  localparam int   NumItems = 1650;
  localparam int   IdleLimit = 20000;
  localparam int   DrainCycles = 60;
  localparam int   CoefW = pwb_pkg::CoefW;
  localparam int   NumCoef = pwb_pkg::NumCoef;
  localparam int   PixW = pwb_pkg::PixW;
  localparam int   CoordW = pwb_pkg::CoordW;
  localparam int   AddrW = pwb_pkg::AddrW;
  localparam int   DataW = pwb_pkg::DataW;
  localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pwb_pkg::pwb_in_t  in_item_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pwb_pkg::pwb_out_t out_item_o;

  warp_scoreboard    sb = new();
  int                items_sent = 0;
  int                idle_cycles = 0;
  bit                hold_req = 1'b0;

  perspective_warp_bilinear dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .in_item_i, .out_valid_o, .out_stall_i, .out_item_o
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_pixel(out_item_o);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly short random lengths, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        n = pick_gap();
        out_stall_i <= (n != 0);
        repeat (n == 0 ? $urandom_range(1, 4) : n) @(posedge clk_i);
      end
    end
  end

  task automatic apb_write(pwb_pkg::pwb_reg_e idx, logic [CoefW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(8 * int'(idx));
    pwdata  <= {{(DataW-CoefW){val[CoefW-1]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_coef(idx, val);
  endtask

  // offer one item and wait for it to be taken
  task automatic send_item(pwb_pkg::pwb_in_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_load(int col, int row, logic [PixW-1:0] rgb);
    pwb_pkg::pwb_in_t it;
    it = {ModeLoad, CoordW'(col), CoordW'(row), rgb};
    send_item(it);
  endtask

  task automatic send_warp(int col, int row);
    pwb_pkg::pwb_in_t it;
    it = {ModeWarp, CoordW'(col), CoordW'(row), PixW'($urandom())};
    send_item(it);
  endtask

  // pick a warp that only reads loaded pixels, else fall back to a stray load
  task automatic send_random_warp();
    pwb_pkg::pwb_out_t res;
    int col, row;
    for (int t = 0; t < 200; t++) begin
      if ($urandom_range(0, 9) == 0) begin
        col = $urandom_range(0, 4095);
        row = $urandom_range(0, 4095);
      end else begin
        col = $urandom_range(0, 40);
        row = $urandom_range(0, 40);
      end
      if (sb.warp_pixel(col, row, res)) begin
        send_warp(col, row);
        return;
      end
    end
    send_load($urandom_range(512, 4095), $urandom_range(0, 4095), PixW'($urandom()));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pixels_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_coefs(logic [CoefW-1:0] c [NumCoef]);
    wait_idle();
    for (int i = 0; i < NumCoef; i++) apb_write(pwb_pkg::pwb_reg_e'(i), c[i]);
  endtask

  function automatic logic [CoefW-1:0] rnd_coef(longint lo, longint hi);
    longint r;
    r = lo + longint'({$urandom(), $urandom()} % (hi - lo + 1));
    return CoefW'(r);
  endfunction

  // random coefficient set, mostly one that lands in the loaded patch
  task automatic random_coefs();
    logic [CoefW-1:0] c [NumCoef];
    longint one;
    one = 64'sd1 <<< 32;
    if ($urandom_range(0, 7) == 0) begin
      foreach (c[i]) c[i] = CoefW'({$urandom(), $urandom()});
    end else begin
      c[pwb_pkg::REG_H00] = rnd_coef(one / 4, one);
      c[pwb_pkg::REG_H01] = rnd_coef(-one / 16, one / 16);
      c[pwb_pkg::REG_H02] = rnd_coef(0, 4 * one);
      c[pwb_pkg::REG_H10] = rnd_coef(-one / 16, one / 16);
      c[pwb_pkg::REG_H11] = rnd_coef(one / 4, one);
      c[pwb_pkg::REG_H12] = rnd_coef(0, 4 * one);
      c[pwb_pkg::REG_H20] = rnd_coef(-one / 512, one / 512);
      c[pwb_pkg::REG_H21] = rnd_coef(-one / 512, one / 512);
    end
    load_coefs(c);
  endtask

  initial begin
    logic [CoefW-1:0] c [NumCoef];
    longint one;
    one = 64'sd1 <<< 32;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // source patch at the origin and at the far corner
    for (int r = 0; r < 16; r++)
      for (int k = 0; k < 16; k++) send_load(k, r, PixW'($urandom()));
    send_load(0, 0, '0);
    send_load(1, 0, '1);
    for (int r = 508; r < 512; r++)
      for (int k = 508; k < 512; k++) send_load(k, r, PixW'($urandom()));
    // loads past the edge are dropped
    send_load(512, 0, '1);
    send_load(4095, 4095, '1);
    send_load(0, 512, '1);

    // identity: exact pixels, corner clamp, outside
    send_warp(0, 0);
    send_warp(1, 0);
    send_warp(14, 14);
    send_warp(511, 511);
    send_warp(511, 508);
    send_warp(512, 0);
    send_warp(0, 512);
    send_warp(4095, 4095);

    // half scale with quarter offset gives fractional weights
    c = '{one / 2, 0, one / 4, 0, one / 2, one / 4, 0, 0};
    load_coefs(c);
    send_warp(0, 0);
    send_warp(3, 5);
    send_warp(29, 29);
    send_warp(29, 1);

    // zero denominator and negative denominator
    c = '{-4 * one, 0, 0, 0, -4 * one, 0, -one, 0};
    load_coefs(c);
    send_warp(1, 0);
    send_warp(2, 0);
    send_warp(3, 1);
    send_warp(0, 0);

    // extreme coefficients
    c = '{CoefMax, CoefMin, CoefMax, CoefMin, CoefMax, CoefMin, CoefMax, CoefMin};
    load_coefs(c);
    send_warp(4095, 4095);
    send_warp(1, 0);
    send_warp(0, 1);
    c = '{CoefMin, CoefMax, CoefMin, CoefMax, CoefMin, CoefMax, CoefMin, CoefMax};
    load_coefs(c);
    send_warp(4095, 0);
    send_warp(0, 0);

    // random phases; the receiver holds off once while items keep coming
    while (items_sent < NumItems) begin
      random_coefs();
      if (items_sent > 600 && items_sent < 800) hold_req = 1'b1;
      repeat ($urandom_range(60, 160)) begin
        if ($urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1) == 0)
            send_load($urandom_range(0, 15), $urandom_range(0, 15), PixW'($urandom()));
          else
            send_load($urandom_range(0, 4095), $urandom_range(0, 4095),
                      PixW'($urandom()));
        end else begin
          send_random_warp();
        end
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
